// File: hdl/utf8d_pkg.sv
// Shared types and codes for the UTF-8 validating decoder.
// No dependencies; every other file of the block but utf8d_fifo imports this package.
package utf8d_pkg;

	// Byte classes found by the front classifier
	typedef enum logic [2:0] {
		K_ASCII,
		K_LEAD2,
		K_LEAD3,
		K_LEAD4,
		K_CONT,
		K_BAD
	} kind_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEAD = 3'd1,
		ST_BAD_CONT = 3'd2,
		ST_RANGE    = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	// Smallest legal value for each sequence length, and the largest legal code point
	localparam logic [20:0] MIN_TWO   = 21'h00080;
	localparam logic [20:0] MIN_THREE = 21'h00800;
	localparam logic [20:0] MIN_FOUR  = 21'h10000;
	localparam logic [20:0] MAX_CP    = 21'h10FFFF;

	// Classified byte handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [6:0] bits;  // payload bits, right aligned and masked
		logic       last;
	} cls_item_t;

	localparam int CLS_W = $bits(cls_item_t);

	// Result item
	typedef struct packed {
		logic [20:0] code_point;
		logic [2:0]  seq_length;
		status_t     status;
	} res_item_t;

	localparam int RES_W = $bits(res_item_t);

endpackage

// File: hdl/utf8d_fifo.sv
// Small register-based queue with push/full and pop/empty handshakes.
// Generic; used between front and back and on the result side.
module utf8d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2   // two or more
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/utf8d_front.sv
// Front end: accepts raw bytes, classifies them and queues the classes.
// Depends on utf8d_pkg and utf8d_fifo.
module utf8d_front #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           data_byte,
	input  logic                 buffer_end,
	input  logic                 cls_pop,
	output logic                 cls_empty,
	output utf8d_pkg::cls_item_t cls_item
);

	import utf8d_pkg::*;

	cls_item_t        cls_new;
	logic [CLS_W-1:0] cls_raw;

	// byte classifier
	always_comb begin
		cls_new.last = buffer_end;
		unique casez (data_byte)
			8'b0???_????: begin
				cls_new.kind = K_ASCII;
				cls_new.bits = data_byte[6:0];
			end
			8'b10??_????: begin
				cls_new.kind = K_CONT;
				cls_new.bits = {1'b0, data_byte[5:0]};
			end
			8'b110?_????: begin
				cls_new.kind = K_LEAD2;
				cls_new.bits = {2'b0, data_byte[4:0]};
			end
			8'b1110_????: begin
				cls_new.kind = K_LEAD3;
				cls_new.bits = {3'b0, data_byte[3:0]};
			end
			8'b1111_0???: begin
				cls_new.kind = K_LEAD4;
				cls_new.bits = {4'b0, data_byte[2:0]};
			end
			default: begin
				cls_new.kind = K_BAD;
				cls_new.bits = '0;
			end
		endcase
	end

	// queue towards the back end
	utf8d_fifo #(
		.WIDTH(CLS_W),
		.DEPTH(DEPTH)
	) u_cls_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls_new),
		.full  (full),
		.pop   (cls_pop),
		.rdata (cls_raw),
		.empty (cls_empty)
	);

	assign cls_item = cls_raw;

endmodule

// File: hdl/utf8d_back.sv
// Back end: sequence tracker that gathers payload bits and forms results.
// Depends on utf8d_pkg.
module utf8d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cls_empty,
	input  utf8d_pkg::cls_item_t cls_item,
	output logic                 cls_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output utf8d_pkg::res_item_t res_item
);

	import utf8d_pkg::*;

	logic [20:0] partial_q;
	logic [1:0]  remaining_q;
	logic [2:0]  length_q;

	logic [20:0] partial_d;
	logic [1:0]  remaining_d;
	logic [2:0]  length_d;
	logic [20:0] cont_bits;
	logic [20:0] merged;
	logic [1:0]  rem_next;
	logic [2:0]  consumed;
	logic        out_of_range;

	// take a class item only when the result queue has room
	assign cls_pop = ~cls_empty & ~res_full;

	// continuation payload placed by the count still expected
	always_comb begin
		case (remaining_q)
			2'd3:    cont_bits = {3'b0, cls_item.bits[5:0], 12'b0};
			2'd2:    cont_bits = {9'b0, cls_item.bits[5:0], 6'b0};
			default: cont_bits = {15'b0, cls_item.bits[5:0]};
		endcase
	end

	assign merged   = partial_q | cont_bits;
	assign rem_next = remaining_q - 2'd1;
	assign consumed = length_q - {1'b0, remaining_q} + 3'd1;

	// overlong or beyond the last scalar value
	always_comb begin
		case (length_q)
			3'd4:    out_of_range = (merged < MIN_FOUR) || (merged > MAX_CP);
			3'd3:    out_of_range = (merged < MIN_THREE);
			default: out_of_range = (merged < MIN_TWO);
		endcase
	end

	// sequence step
	always_comb begin
		partial_d           = partial_q;
		remaining_d         = remaining_q;
		length_d            = length_q;
		res_push            = 1'b0;
		res_item.code_point = '0;
		res_item.seq_length = 3'd1;
		res_item.status     = ST_OK;
		if (cls_pop) begin
			if (remaining_q == 2'd0) begin
				unique case (cls_item.kind)
					K_ASCII: begin
						res_push            = 1'b1;
						res_item.code_point = {14'b0, cls_item.bits};
					end
					K_LEAD2, K_LEAD3, K_LEAD4: begin
						if (cls_item.last) begin
							res_push        = 1'b1;
							res_item.status = ST_TRUNC;
						end else begin
							unique case (cls_item.kind)
								K_LEAD4: begin
									partial_d   = {cls_item.bits[2:0], 18'b0};
									length_d    = 3'd4;
									remaining_d = 2'd3;
								end
								K_LEAD3: begin
									partial_d   = {5'b0, cls_item.bits[3:0], 12'b0};
									length_d    = 3'd3;
									remaining_d = 2'd2;
								end
								default: begin
									partial_d   = {10'b0, cls_item.bits[4:0], 6'b0};
									length_d    = 3'd2;
									remaining_d = 2'd1;
								end
							endcase
						end
					end
					default: begin
						res_push        = 1'b1;
						res_item.status = ST_BAD_LEAD;
					end
				endcase
			end else if (cls_item.kind != K_CONT) begin
				// broken sequence
				res_push            = 1'b1;
				res_item.seq_length = consumed;
				res_item.status     = ST_BAD_CONT;
				partial_d           = '0;
				remaining_d         = 2'd0;
				length_d            = 3'd0;
			end else if (rem_next != 2'd0) begin
				if (cls_item.last) begin
					res_push            = 1'b1;
					res_item.seq_length = consumed;
					res_item.status     = ST_TRUNC;
					partial_d           = '0;
					remaining_d         = 2'd0;
					length_d            = 3'd0;
				end else begin
					partial_d   = merged;
					remaining_d = rem_next;
				end
			end else begin
				// final continuation
				res_push            = 1'b1;
				res_item.seq_length = length_q;
				if (out_of_range) begin
					res_item.status = ST_RANGE;
				end else begin
					res_item.code_point = merged;
				end
				partial_d   = '0;
				remaining_d = 2'd0;
				length_d    = 3'd0;
			end
		end
	end

	// sequence state, zero means idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q   <= '0;
			remaining_q <= '0;
			length_q    <= '0;
		end else begin
			partial_q   <= partial_d;
			remaining_q <= remaining_d;
			length_q    <= length_d;
		end
	end

endmodule

// File: hdl/utf8_validating_decoder_core.sv
// Top level of the UTF-8 validating decoder: front classifier, back tracker
// and result queue. Depends on utf8d_pkg, utf8d_front, utf8d_back, utf8d_fifo.
//
// Bytes are pushed one per cycle (push while full is low) and results are
// popped from a queue (pop while empty is low). A byte is classified and
// queued at the edge that accepts it; the sequence tracker consumes one
// classified byte per cycle while the result queue has room, so the sustained
// rate is one byte per cycle, set by the registered state update of the
// tracker. The result of the byte that completes a sequence is registered in
// the result queue before it appears on the result ports.
// Each byte yields at most one result: the code point with its length, or
// an error status with code point zero. CLS_DEPTH and RES_DEPTH size the
// internal queues and must be two or more.
module utf8_validating_decoder_core #(
	parameter int CLS_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	output logic        empty,
	input  logic        pop,
	output logic [20:0] code_point,
	output logic [2:0]  seq_length,
	output logic [2:0]  status
);

	import utf8d_pkg::*;

	cls_item_t        cls_item;
	logic             cls_empty;
	logic             cls_pop;
	logic             res_full;
	logic             res_push;
	res_item_t        res_new;
	logic [RES_W-1:0] res_raw;
	res_item_t        res_out;

	// byte intake and classification
	utf8d_front #(
		.DEPTH(CLS_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.buffer_end(buffer_end),
		.cls_pop   (cls_pop),
		.cls_empty (cls_empty),
		.cls_item  (cls_item)
	);

	// sequence tracking
	utf8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cls_empty(cls_empty),
		.cls_item (cls_item),
		.cls_pop  (cls_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_new)
	);

	// result queue
	utf8d_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_new),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign res_out    = res_raw;
	assign code_point = res_out.code_point;
	assign seq_length = res_out.seq_length;
	assign status     = res_out.status;

endmodule

// File: sim/utf8_validating_decoder_core_tb.sv
// Self-checking testbench for utf8_validating_decoder_core: directed and random byte streams,
// each result checked against a behavioural decoder kept in this file.
// Depends on utf8d_pkg and the RTL of the decoder core.
`timescale 1ns / 100ps

module utf8_validating_decoder_core_tb;
	import utf8d_pkg::*;

	// Range limits of the decoded value per sequence length
	localparam logic [20:0] FLOOR_2B = 21'h00080;
	localparam logic [20:0] FLOOR_3B = 21'h00800;
	localparam logic [20:0] FLOOR_4B = 21'h10000;
	localparam logic [20:0] CEIL_CP  = 21'h10FFFF;

	localparam int N_RANDOM    = 950;
	localparam int QUIET_LO    = 300;    // no idling on either side in this window of items
	localparam int QUIET_HI    = 480;
	localparam int HOLD_AT     = 700;    // receiver stops popping once this many items are in
	localparam int HOLD_LEN    = 150;
	localparam int TAIL_CYCLES = 16;
	localparam int CYCLE_LIMIT = 100000;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         drain;  // sender waits for all results before offering this item
	} byte_item_t;

	typedef struct {
		logic [20:0] cp;
		logic [2:0]  len;
		status_t     st;
	} decoded_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        buffer_end = 1'b0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [20:0] code_point;
	logic [2:0]  seq_length;
	logic [2:0]  status;

	byte_item_t pending[$];
	decoded_t   exp_q[$];
	bit         next_drain = 1'b0;
	int         n_items = 0;
	int         n_taken = 0;
	int         n_cycles = 0;
	int         n_mismatch = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;

	// Decoder state as seen by the predictor; all zero means idle
	logic [20:0] acc_val = '0;
	logic [1:0]  left = '0;
	logic [2:0]  seq_len = '0;

	utf8_validating_decoder_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.empty      (empty),
		.pop        (pop),
		.code_point (code_point),
		.seq_length (seq_length),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", n_cycles, what);
		n_mismatch++;
	endtask

	task automatic expect_result(input logic [20:0] cp, input logic [2:0] len, input status_t st);
		decoded_t d;
		d.cp = cp;
		d.len = len;
		d.st = st;
		exp_q.push_back(d);
	endtask

	task automatic return_idle();
		acc_val = '0;
		left = '0;
		seq_len = '0;
	endtask

	// Predictor: one accepted byte, zero or one expected result
	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic [2:0]  used;
		logic [20:0] v;
		logic        bad;
		int          sh;
		if (left == 2'd0) begin
			if (!b[7]) begin
				expect_result({13'd0, b}, 3'd1, ST_OK);
			end else if (b[7:3] == 5'b11110 || b[7:4] == 4'b1110 || b[7:5] == 3'b110) begin
				if (last) begin
					expect_result('0, 3'd1, ST_TRUNC);
				end else begin
					if (b[7:3] == 5'b11110) begin
						seq_len = 3'd4;
						acc_val = {b[2:0], 18'd0};
					end else if (b[7:4] == 4'b1110) begin
						seq_len = 3'd3;
						acc_val = {5'd0, b[3:0], 12'd0};
					end else begin
						seq_len = 3'd2;
						acc_val = {10'd0, b[4:0], 6'd0};
					end
					left = 2'(seq_len - 3'd1);
				end
			end else begin
				expect_result('0, 3'd1, ST_BAD_LEAD);
			end
		end else begin
			used = seq_len - 3'(left) + 3'd1;
			if (b[7:6] != 2'b10) begin
				return_idle();
				expect_result('0, used, ST_BAD_CONT);
			end else begin
				sh = 6 * (int'(left) - 1);
				acc_val = acc_val | (21'(b[5:0]) << sh);
				left = left - 2'd1;
				if (left != 2'd0) begin
					if (last) begin
						return_idle();
						expect_result('0, used, ST_TRUNC);
					end
				end else begin
					v = acc_val;
					case (seq_len)
						3'd4: bad = (v < FLOOR_4B) || (v > CEIL_CP);
						3'd3: bad = v < FLOOR_3B;
						default: bad = v < FLOOR_2B;
					endcase
					used = seq_len;
					return_idle();
					if (bad)
						expect_result('0, used, ST_RANGE);
					else
						expect_result(v, used, ST_OK);
				end
			end
		end
	endtask

	// Random idle draw, suppressed inside the quiet window
	function automatic bit skip_cycle();
		if (n_taken >= QUIET_LO && n_taken < QUIET_HI)
			return 1'b0;
		return $urandom_range(99) < 19;
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic last);
		byte_item_t it;
		it.b = b;
		it.last = last;
		it.drain = next_drain;
		next_drain = 1'b0;
		pending.push_back(it);
	endtask

	// Encode one sequence; broken > 0 replaces that continuation with a random byte
	task automatic add_seq(input int len, input logic [20:0] v, input int broken);
		logic [7:0] bytes[4];
		int         i;
		bytes = '{default: 8'h00};
		case (len)
			1: bytes[0] = {1'b0, v[6:0]};
			2: begin
				bytes[0] = {3'b110, v[10:6]};
				bytes[1] = {2'b10, v[5:0]};
			end
			3: begin
				bytes[0] = {4'b1110, v[15:12]};
				bytes[1] = {2'b10, v[11:6]};
				bytes[2] = {2'b10, v[5:0]};
			end
			default: begin
				bytes[0] = {5'b11110, v[20:18]};
				bytes[1] = {2'b10, v[17:12]};
				bytes[2] = {2'b10, v[11:6]};
				bytes[3] = {2'b10, v[5:0]};
			end
		endcase
		if (broken > 0 && broken < len)
			bytes[broken] = 8'($urandom_range(255));
		for (i = 0; i < len; i++)
			add_byte(bytes[i], $urandom_range(19) == 0);
	endtask

	// Value for a sequence length: mostly legal, sometimes anywhere in the field
	function automatic logic [20:0] pick_value(input int len);
		bit wide;
		wide = $urandom_range(3) == 0;
		case (len)
			1: return 21'($urandom_range(127));
			2: return wide ? 21'($urandom_range(21'h7FF)) : 21'($urandom_range(21'h7FF, 21'h80));
			3: return wide ? 21'($urandom_range(21'hFFFF)) : 21'($urandom_range(21'hFFFF, 21'h800));
			default: return wide ? 21'($urandom_range(21'h1FFFFF))
				: 21'($urandom_range(21'h10FFFF, 21'h10000));
		endcase
	endfunction

	// Stimulus, reset and end of run
	initial begin
		int  r;
		int  len;
		int  n_dir;
		bit  mid_drain;
		mid_drain = 1'b0;

		// directed: ascii extremes, bad leads, range edges, surrogate, broken sequence, truncation
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b1);
		add_byte(8'h80, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'hC1, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hE0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0); add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b1);
		add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hE2, 1'b1);
		add_byte(8'hC3, 1'b0); add_byte(8'h41, 1'b0);
		add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
		n_dir = pending.size();

		// random: mostly well-formed sequences, the rest broken ones and raw noise
		next_drain = 1'b1;
		while (pending.size() < n_dir + N_RANDOM) begin
			if (!mid_drain && pending.size() >= n_dir + N_RANDOM / 2) begin
				next_drain = 1'b1;
				mid_drain = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 80) begin
				len = $urandom_range(4, 1);
				add_seq(len, pick_value(len), 0);
			end else if (r < 90) begin
				len = $urandom_range(4, 2);
				add_seq(len, pick_value(len), $urandom_range(len - 1, 1));
			end else begin
				add_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
		end
		n_items = pending.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken != n_items) @(posedge clk);
		while (exp_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_mismatch == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Driver: offer the next pending byte, hold it while full is high
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				decode_byte(data_byte, buffer_end);
				n_taken <= n_taken + 1;
			end
			if (!push || !full) begin
				if (pending.size() != 0 && !(pending[0].drain && exp_q.size() != 0)
					&& !skip_cycle()) begin
					push <= 1'b1;
					data_byte <= pending[0].b;
					buffer_end <= pending[0].last;
					void'(pending.pop_front());
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Compare the result popped at this edge with the oldest expectation
	task automatic check_result();
		decoded_t want;
		if (exp_q.size() == 0) begin
			flag_mismatch($sformatf("unexpected result cp=%h len=%0d st=%0d",
				code_point, seq_length, status));
		end else begin
			want = exp_q.pop_front();
			if (code_point !== want.cp)
				flag_mismatch($sformatf("code_point %h, want %h", code_point, want.cp));
			if (seq_length !== want.len)
				flag_mismatch($sformatf("seq_length %0d, want %0d", seq_length, want.len));
			if (status !== want.st)
				flag_mismatch($sformatf("status %0d, want %s", status, want.st.name()));
		end
	endtask

	// Monitor: pop at random, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_result();
			if (!hold_done && n_taken >= HOLD_AT) begin
				hold_left = HOLD_LEN;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= !skip_cycle();
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
